>>> src/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  localparam int unsigned RAM_BYTES        = 262144;
  localparam int unsigned ROM_WINDOW_BYTES = 8192;
  localparam int unsigned BANKS            = 4;
  localparam int unsigned BANK_W           = 5;
  localparam int unsigned MODE_W           = 4;
  localparam int unsigned OP_W             = 2;
  localparam int unsigned ADDR_W           = 16;
  localparam int unsigned DATA_W           = 8;

  localparam logic [ADDR_W-1:0] MODE_ADDR   = 16'h3FFF;
  localparam logic [ADDR_W-1:0] WIN_LO      = 16'h4000;
  localparam logic [ADDR_W-1:0] WIN_HI      = 16'hC000;
  localparam logic [ADDR_W-1:0] PAGE2_LO    = 16'h8000;
  localparam logic [ADDR_W-1:0] SWITCH_LO   = 16'h6000;
  localparam logic [ADDR_W-1:0] A16_LOW_HI  = 16'h6800;
  localparam logic [ADDR_W-1:0] A16_HIGH_LO = 16'h7000;
  localparam logic [ADDR_W-1:0] A16_HIGH_HI = 16'h7800;

  localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2
  } op_e;

  // mode bits {2,0}
  typedef enum logic [1:0] {
    SCH_ASCII16 = 2'b00,
    SCH_ASCII8  = 2'b01,
    SCH_UNKNOWN = 2'b10,
    SCH_KONAMI  = 2'b11
  } scheme_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_OPEN,
    SRC_ROM,
    SRC_RAM
  } rd_src_e;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic    ram_re;
    logic    ram_we;
    logic    rom_re;
    logic    rom_we;
    rd_src_e src;
  } acc_t;

endpackage

`default_nettype wire

>>> src/cbm_if.sv
// ----------------------------------------------------------------------------
// cbm_in_if / cbm_out_if
// Valid/ready channels for bus accesses and read results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbm_in_if;
  logic                        valid;
  logic                        ready;
  logic [cbm_pkg::OP_W-1:0]    operation;
  logic [cbm_pkg::ADDR_W-1:0]  address;
  logic [cbm_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

interface cbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [cbm_pkg::DATA_W-1:0]  read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

>>> src/cartridge_bank_mapper_with_ram.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_ram
// Banked cartridge mapper: mode and bank registers, 256 KB banked RAM and an
// 8 KB boot ROM, one bus access per transfer, one result per access.
// ----------------------------------------------------------------------------
//   channel  dir  payload                              role
//   in_i     in   operation, address, write_data       bus access / ROM load
//   out_o    out  read_data                            result of each access
//
// One access per cycle sustained while out_o takes results; each result passes
// the registered RAM or ROM read stage and then the output register before
// out_o offers it.
// After reset the banked RAM is cleared one byte a cycle, all 262144 bytes,
// with in_i.ready low. A stalled result holds the read stage; in_i.ready then
// drops until out_o takes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_with_ram #(
  parameter int unsigned RamBytes = cbm_pkg::RAM_BYTES,
  parameter int unsigned RomBytes = cbm_pkg::ROM_WINDOW_BYTES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cbm_in_if.sink     in_i,
  cbm_out_if.source  out_o
);

  localparam int unsigned RamAw = $clog2(RamBytes);
  localparam int unsigned RomAw = $clog2(RomBytes);

  cbm_pkg::state_e            state_q, state_d;
  logic [RamAw-1:0]           clr_cnt_q, clr_cnt_d;
  cbm_pkg::acc_t              ctl;
  logic [RamAw-1:0]           ram_addr;
  logic                       accept;
  logic                       out_free;
  logic                       clearing;
  logic                       p1_valid_q;
  cbm_pkg::rd_src_e           p1_src_q;
  logic                       out_valid_q;
  logic [cbm_pkg::DATA_W-1:0] read_data_q, read_data_d;
  logic                       ram_en, ram_we;
  logic [RamAw-1:0]           ram_a;
  logic [cbm_pkg::DATA_W-1:0] ram_wd, ram_rd;
  logic [cbm_pkg::DATA_W-1:0] rom_rd;
  logic                       rom_en;

  assign clearing   = (state_q == cbm_pkg::ST_CLEAR);
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !clearing && (!p1_valid_q || out_free);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      cbm_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = cbm_pkg::ST_RUN;
        end
      end
      cbm_pkg::ST_RUN: begin
        state_d = cbm_pkg::ST_RUN;
      end
      default: begin
        state_d = cbm_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cbm_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  cbm_bank #(
    .RamAw (RamAw)
  ) u_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (accept),
    .op_i       (in_i.operation),
    .addr_i     (in_i.address),
    .wdata_i    (in_i.write_data),
    .ctl_o      (ctl),
    .ram_addr_o (ram_addr)
  );

  assign ram_en = clearing || (accept && (ctl.ram_re || ctl.ram_we));
  assign ram_we = clearing || ctl.ram_we;
  assign ram_a  = clearing ? clr_cnt_q : ram_addr;
  assign ram_wd = clearing ? '0 : in_i.write_data;

  cbm_ram #(
    .Width (cbm_pkg::DATA_W),
    .Depth (RamBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_a),
    .wdata_i (ram_wd),
    .rdata_o (ram_rd)
  );

  assign rom_en = accept && (ctl.rom_re || ctl.rom_we);

  cbm_ram #(
    .Width (cbm_pkg::DATA_W),
    .Depth (RomBytes)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (rom_en),
    .we_i    (ctl.rom_we),
    .addr_i  (in_i.address[RomAw-1:0]),
    .wdata_i (in_i.write_data),
    .rdata_o (rom_rd)
  );

  always_comb begin
    case (p1_src_q)
      cbm_pkg::SRC_OPEN: read_data_d = cbm_pkg::OPEN_BUS;
      cbm_pkg::SRC_ROM:  read_data_d = rom_rd;
      cbm_pkg::SRC_RAM:  read_data_d = ram_rd;
      default:           read_data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p1_valid_q  <= accept || (p1_valid_q && !out_free);
      if (out_free) begin
        out_valid_q <= p1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_src_q <= ctl.src;
    end
    if (out_free && p1_valid_q) begin
      read_data_q <= read_data_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = read_data_q;

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_i.ready)
    else $error("transfer taken during RAM clear");

  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctl.ram_re) |-> !ctl.ram_we)
    else $error("RAM read and write in one cycle");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && out_valid_q && !out_o.ready) |=> (p1_valid_q && out_valid_q))
    else $error("pending result dropped under stall");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> p1_valid_q)
    else $error("accepted transfer lost");

endmodule

`default_nettype wire

>>> src/cbm_ram.sv
// ----------------------------------------------------------------------------
// cbm_ram
// Generic single-port synchronous RAM, registered read, read data held
// while the port is idle or writing.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/cbm_bank.sv
// ----------------------------------------------------------------------------
// cbm_bank
// Mode and bank registers, access decode and RAM address generation.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_bank #(
  parameter int unsigned RamAw = 18
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         acc_i,
  input  wire logic [cbm_pkg::OP_W-1:0]     op_i,
  input  wire logic [cbm_pkg::ADDR_W-1:0]   addr_i,
  input  wire logic [cbm_pkg::DATA_W-1:0]   wdata_i,
  output cbm_pkg::acc_t                     ctl_o,
  output logic      [RamAw-1:0]             ram_addr_o
);

  logic [cbm_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [cbm_pkg::BANK_W-1:0] bank_q [cbm_pkg::BANKS];
  logic [cbm_pkg::BANK_W-1:0] bank_d [cbm_pkg::BANKS];
  logic                       in_win;
  logic [1:0]                 page;
  logic                       wr;
  logic [3:0]                 half;
  cbm_pkg::scheme_e           scheme;

  assign in_win = (addr_i >= cbm_pkg::WIN_LO) && (addr_i < cbm_pkg::WIN_HI);
  assign page   = 2'(addr_i[15:13] - 3'd2);
  assign scheme = cbm_pkg::scheme_e'({mode_q[2], mode_q[0]});
  assign wr     = acc_i && (cbm_pkg::op_e'(op_i) == cbm_pkg::OP_WRITE);
  assign half   = wdata_i[3:0];

  // address taken from banks before this access updates them
  assign ram_addr_o = RamAw'({bank_q[page], addr_i[12:0]});

  always_comb begin
    ctl_o     = '0;
    ctl_o.src = cbm_pkg::SRC_ZERO;
    case (cbm_pkg::op_e'(op_i))
      cbm_pkg::OP_READ: begin
        if (!in_win) begin
          ctl_o.src = cbm_pkg::SRC_OPEN;
        end else if (!mode_q[3] && (addr_i < cbm_pkg::PAGE2_LO)) begin
          ctl_o.src    = cbm_pkg::SRC_ROM;
          ctl_o.rom_re = 1'b1;
        end else begin
          ctl_o.src    = cbm_pkg::SRC_RAM;
          ctl_o.ram_re = 1'b1;
        end
      end
      cbm_pkg::OP_WRITE: begin
        ctl_o.ram_we = in_win && !mode_q[3] && (addr_i[15] || mode_q[1]);
      end
      cbm_pkg::OP_LOAD: begin
        ctl_o.rom_we = 1'b1;
      end
      default: begin
        ctl_o.src = cbm_pkg::SRC_ZERO;
      end
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    bank_d = bank_q;
    if (wr) begin
      if (addr_i == cbm_pkg::MODE_ADDR) begin
        mode_d = wdata_i[cbm_pkg::MODE_W-1:0];
      end else if (in_win && !mode_q[1]) begin
        case (scheme)
          cbm_pkg::SCH_ASCII16: begin
            if ((addr_i >= cbm_pkg::SWITCH_LO) && (addr_i < cbm_pkg::A16_LOW_HI)) begin
              bank_d[0] = {half, 1'b0};
              bank_d[1] = {half, 1'b1};
            end
            if ((addr_i >= cbm_pkg::A16_HIGH_LO) && (addr_i < cbm_pkg::A16_HIGH_HI)) begin
              bank_d[2] = {half, 1'b0};
              bank_d[3] = {half, 1'b1};
            end
          end
          cbm_pkg::SCH_ASCII8: begin
            if ((addr_i >= cbm_pkg::SWITCH_LO) && (addr_i < cbm_pkg::PAGE2_LO)) begin
              bank_d[addr_i[12:11]] = wdata_i[cbm_pkg::BANK_W-1:0];
            end
          end
          cbm_pkg::SCH_KONAMI: begin
            if (addr_i >= cbm_pkg::SWITCH_LO) begin
              bank_d[page] = wdata_i[cbm_pkg::BANK_W-1:0];
            end
          end
          default: begin
            mode_d = mode_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      for (int i = 0; i < cbm_pkg::BANKS; i++) begin
        bank_q[i] <= '0;
      end
    end else begin
      mode_q <= mode_d;
      bank_q <= bank_d;
    end
  end

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Bus access checker for cartridge_bank_mapper_with_ram.
// A scoreboard keeps its own copy of the mode register, the bank registers,
// the banked RAM and the boot ROM. It predicts the byte returned for every
// accepted access. A directed set covers the window edges, every switching
// scheme and the mode bits. Random accesses follow, with the offsets kept
// near bank boundaries so that reads find data that was written earlier.
// Both channels idle at random.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned    NumItems   = 1300;
  localparam int unsigned    MaxReports = 20;
  localparam longint         TimeoutNs  = 64'd20_000_000;
  localparam logic [cbm_pkg::OP_W-1:0] OpUnused = 2'd3;
  // mode register bits
  localparam int unsigned ModeSelLo  = 0;
  localparam int unsigned ModeRamWr  = 1;
  localparam int unsigned ModeSelHi  = 2;
  localparam int unsigned ModeWrProt = 3;

  class mapper_scoreboard;
    logic [cbm_pkg::MODE_W-1:0] mode;
    logic [cbm_pkg::BANK_W-1:0] bank [cbm_pkg::BANKS];
    bit   [cbm_pkg::DATA_W-1:0] ram [cbm_pkg::RAM_BYTES];
    bit   [cbm_pkg::DATA_W-1:0] rom [cbm_pkg::ROM_WINDOW_BYTES];
    bit                         rom_loaded [cbm_pkg::ROM_WINDOW_BYTES];
    logic [12:0]                loaded_offs [$];
    logic [cbm_pkg::DATA_W-1:0] expected_reads [$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                mode_writes;

    function new();
      mode = '0;
      foreach (bank[i]) bank[i] = '0;
      errors = 0;
      checked = 0;
      mode_writes = 0;
    endfunction

    function logic [17:0] ram_index(logic [cbm_pkg::ADDR_W-1:0] addr);
      logic [1:0] page;
      page = 2'(addr[15:13] - 3'd2);
      return {bank[page], addr[12:0]};
    endfunction

    function void note_access(logic [cbm_pkg::OP_W-1:0] op, logic [cbm_pkg::ADDR_W-1:0] addr,
                              logic [cbm_pkg::DATA_W-1:0] data);
      logic [cbm_pkg::DATA_W-1:0] rd;
      logic [17:0]                target;
      logic                       in_win;
      rd = '0;
      in_win = (addr >= cbm_pkg::WIN_LO) && (addr < cbm_pkg::WIN_HI);
      case (op)
        cbm_pkg::OP_READ: begin
          if (!in_win) rd = cbm_pkg::OPEN_BUS;
          else if (!mode[ModeWrProt] && addr < cbm_pkg::PAGE2_LO) rd = rom[addr[12:0]];
          else rd = ram[ram_index(addr)];
        end
        cbm_pkg::OP_WRITE: begin
          if (addr == cbm_pkg::MODE_ADDR) begin
            mode = data[cbm_pkg::MODE_W-1:0];
            mode_writes++;
          end else if (in_win) begin
            // RAM address uses the banks before this write switches them
            target = ram_index(addr);
            if (!mode[ModeRamWr]) begin
              case (cbm_pkg::scheme_e'({mode[ModeSelHi], mode[ModeSelLo]}))
                cbm_pkg::SCH_ASCII16: begin
                  if (addr >= cbm_pkg::SWITCH_LO && addr < cbm_pkg::A16_LOW_HI) begin
                    bank[0] = {data[3:0], 1'b0};
                    bank[1] = {data[3:0], 1'b1};
                  end
                  if (addr >= cbm_pkg::A16_HIGH_LO && addr < cbm_pkg::A16_HIGH_HI) begin
                    bank[2] = {data[3:0], 1'b0};
                    bank[3] = {data[3:0], 1'b1};
                  end
                end
                cbm_pkg::SCH_ASCII8: begin
                  if (addr >= cbm_pkg::SWITCH_LO && addr < cbm_pkg::PAGE2_LO)
                    bank[addr[12:11]] = data[4:0];
                end
                cbm_pkg::SCH_KONAMI: begin
                  if (addr >= cbm_pkg::SWITCH_LO) bank[2'(addr[15:13] - 3'd2)] = data[4:0];
                end
                default: ;
              endcase
            end
            if (!mode[ModeWrProt] && (addr >= cbm_pkg::PAGE2_LO || mode[ModeRamWr]))
              ram[target] = data;
          end
        end
        cbm_pkg::OP_LOAD: begin
          rom[addr[12:0]] = data;
          if (!rom_loaded[addr[12:0]]) begin
            rom_loaded[addr[12:0]] = 1'b1;
            loaded_offs.push_back(addr[12:0]);
          end
        end
        default: ;
      endcase
      expected_reads.push_back(rd);
    endfunction

    function void check_result(logic [cbm_pkg::DATA_W-1:0] actual);
      logic [cbm_pkg::DATA_W-1:0] exp_rd;
      if (expected_reads.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected result, expected none, actual read_data=0x%02h",
                   $time, actual);
        return;
      end
      exp_rd = expected_reads.pop_front();
      checked++;
      if (actual !== exp_rd) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: read_data mismatch, expected 0x%02h, actual 0x%02h",
                   $time, exp_rd, actual);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   no_idle;
  logic [12:0] hot_offs [8];
  mapper_scoreboard sb;

  cbm_in_if  in_if ();
  cbm_out_if out_if ();

  cartridge_bank_mapper_with_ram i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [cbm_pkg::ADDR_W-1:0] window_addr();
    logic [2:0]  page;
    logic [12:0] offs;
    page = 3'd2 + 3'($urandom_range(3));
    if ($urandom_range(99) < 70) offs = hot_offs[$urandom_range(7)];
    else offs = 13'($urandom_range(8191));
    return {page, offs};
  endfunction

  function automatic logic [cbm_pkg::ADDR_W-1:0] outside_addr();
    logic [13:0] low;
    low = 14'($urandom_range(16383));
    return $urandom_range(1) ? {2'b11, low} : {2'b00, low};
  endfunction

  task automatic send_access(logic [cbm_pkg::OP_W-1:0] op, logic [cbm_pkg::ADDR_W-1:0] addr,
                             logic [cbm_pkg::DATA_W-1:0] data, int unsigned gap);
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.address    <= addr;
    in_if.write_data <= data;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_access(op, addr, data);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_reads.size() != 0);
  endtask

  task automatic random_access(output logic [cbm_pkg::OP_W-1:0] op,
                               output logic [cbm_pkg::ADDR_W-1:0] addr,
                               output logic [cbm_pkg::DATA_W-1:0] data);
    int unsigned r;
    logic [3:0]  nib;
    logic [3:0]  hi;
    r = $urandom_range(99);
    data = 8'($urandom_range(255));
    if (r < 12) begin
      op = cbm_pkg::OP_LOAD;
      addr = 16'($urandom_range(65535));
    end else if (r < 14) begin
      op = OpUnused;
      addr = 16'($urandom_range(65535));
    end else if (r < 52) begin
      op = cbm_pkg::OP_READ;
      addr = ($urandom_range(9) == 0) ? outside_addr() : window_addr();
      // page-1 ROM reads only touch loaded bytes
      if (!sb.mode[ModeWrProt] && addr >= cbm_pkg::WIN_LO && addr < cbm_pkg::PAGE2_LO) begin
        if (sb.loaded_offs.size() == 0) begin
          op = cbm_pkg::OP_LOAD;
          addr = 16'($urandom_range(65535));
        end else begin
          addr = {addr[15:13], sb.loaded_offs[$urandom_range(sb.loaded_offs.size() - 1)]};
        end
      end
    end else begin
      op = cbm_pkg::OP_WRITE;
      r = $urandom_range(99);
      if (r < 8) begin
        if ($urandom_range(9) < 7) nib = {1'b0, 3'($urandom_range(7))};
        else nib = 4'($urandom_range(15));
        hi = 4'($urandom_range(15));
        addr = cbm_pkg::MODE_ADDR;
        data = {hi, nib};
      end else if (r < 16) begin
        addr = outside_addr();
      end else begin
        addr = window_addr();
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.read_data);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        stall = idle_len();
      end
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("FAIL cartridge_bank_mapper_with_ram");
    $finish;
  end

  initial begin : stimulus
    logic [cbm_pkg::OP_W-1:0]   op;
    logic [cbm_pkg::ADDR_W-1:0] addr;
    logic [cbm_pkg::DATA_W-1:0] data;
    int unsigned                iter;
    int unsigned                n_done;
    int unsigned                n_reads;
    int unsigned                n_writes;
    int unsigned                n_loads;
    sb = new();
    hot_offs = '{13'h0000, 13'h07FF, 13'h0800, 13'h0FFF,
                 13'h1000, 13'h17FF, 13'h1800, 13'h1FFF};
    rst_ni           = 1'b0;
    no_idle          = 1'b0;
    in_if.valid      = 1'b0;
    in_if.operation  = cbm_pkg::OP_READ;
    in_if.address    = '0;
    in_if.write_data = '0;
    out_if.ready     = 1'b0;
    iter = 0;
    n_done = 0;
    n_reads = 0;
    n_writes = 0;
    n_loads = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: ROM wrap, open bus, each scheme, mode bits
    send_access(cbm_pkg::OP_LOAD,  16'h0000, 8'h3C, idle_len());
    send_access(cbm_pkg::OP_LOAD,  16'hFFFF, 8'hC3, idle_len());
    send_access(cbm_pkg::OP_READ,  16'h4000, 8'h00, idle_len());
    send_access(cbm_pkg::OP_READ,  16'h7FFF, 8'h00, idle_len());
    send_access(cbm_pkg::OP_READ,  16'h0000, 8'h00, idle_len());
    send_access(cbm_pkg::OP_READ,  16'hFFFF, 8'h00, idle_len());
    send_access(cbm_pkg::OP_READ,  16'hBFFF, 8'h00, idle_len());
    send_access(cbm_pkg::OP_WRITE, 16'h8000, 8'hFF, idle_len());
    send_access(cbm_pkg::OP_READ,  16'h8000, 8'h00, idle_len());
    send_access(cbm_pkg::OP_WRITE, 16'h7000, 8'hFF, idle_len());
    send_access(cbm_pkg::OP_READ,  16'h8000, 8'h00, idle_len());
    send_access(cbm_pkg::OP_WRITE, 16'h6000, 8'h01, idle_len());
    send_access(cbm_pkg::OP_WRITE, cbm_pkg::MODE_ADDR, 8'hF1, idle_len());
    send_access(cbm_pkg::OP_WRITE, 16'h7800, 8'h00, idle_len());
    send_access(cbm_pkg::OP_WRITE, 16'hA000, 8'h5A, idle_len());
    send_access(cbm_pkg::OP_WRITE, cbm_pkg::MODE_ADDR, 8'h05, idle_len());
    send_access(cbm_pkg::OP_WRITE, 16'hBFFF, 8'h1F, idle_len());
    send_access(cbm_pkg::OP_READ,  16'hBFFF, 8'h00, idle_len());
    send_access(cbm_pkg::OP_WRITE, cbm_pkg::MODE_ADDR, 8'h04, idle_len());
    send_access(cbm_pkg::OP_WRITE, 16'h9000, 8'h42, idle_len());
    send_access(cbm_pkg::OP_WRITE, cbm_pkg::MODE_ADDR, 8'h02, idle_len());
    send_access(cbm_pkg::OP_WRITE, 16'h4000, 8'h77, idle_len());
    send_access(cbm_pkg::OP_WRITE, cbm_pkg::MODE_ADDR, 8'h0A, idle_len());
    send_access(cbm_pkg::OP_READ,  16'h4000, 8'h00, idle_len());
    send_access(cbm_pkg::OP_WRITE, 16'h4000, 8'h11, idle_len());
    send_access(OpUnused,          16'h1234, 8'hAB, idle_len());
    send_access(cbm_pkg::OP_WRITE, cbm_pkg::MODE_ADDR, 8'h00, idle_len());
    drain();

    while (n_done < NumItems) begin
      if (iter % 100 == 0) no_idle = ($urandom_range(3) == 0);
      if (iter % 300 == 150) drain();
      random_access(op, addr, data);
      send_access(op, addr, data, idle_len());
      iter++;
      case (op)
        cbm_pkg::OP_READ:  n_reads++;
        cbm_pkg::OP_WRITE: n_writes++;
        cbm_pkg::OP_LOAD:  n_loads++;
        default: ;
      endcase
      if (op != OpUnused &&
          !(op == cbm_pkg::OP_WRITE && addr != cbm_pkg::MODE_ADDR &&
            (addr < cbm_pkg::WIN_LO || addr >= cbm_pkg::WIN_HI)))
        n_done++;
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Random part: %0d reads, %0d writes, %0d ROM loads; %0d mode settings in all.",
             n_reads, n_writes, n_loads, sb.mode_writes);
    $display("%0d results checked, %0d errors.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_reads.size() == 0) begin
      $display("PASS cartridge_bank_mapper_with_ram");
    end else begin
      $display("FAIL cartridge_bank_mapper_with_ram");
    end
    $finish;
  end

endmodule

>>> sim.f
src/cbm_pkg.sv
src/cbm_if.sv
src/cbm_ram.sv
src/cbm_bank.sv
src/cartridge_bank_mapper_with_ram.sv
bench/testbench.sv
